[rtl/tick_driven_cpu_scheduler_unit_macros.svh]
// assertion macros for the tick driven cpu scheduler
`ifndef TICK_DRIVEN_CPU_SCHEDULER_UNIT_MACROS_SVH
`define TICK_DRIVEN_CPU_SCHEDULER_UNIT_MACROS_SVH

// same-cycle implication
`define TDCS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tdcs assertion failed");

// next-cycle implication
`define TDCS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tdcs assertion failed");

`endif

[rtl/tdcs_pkg.sv]
// shared types and constants for the tick driven cpu scheduler
`default_nettype none

package tdcs_pkg;

	localparam logic [2:0] MODE_SRTF   = 3'd0;
	localparam logic [2:0] MODE_SJF    = 3'd1;
	localparam logic [2:0] MODE_PPRIO  = 3'd2;
	localparam logic [2:0] MODE_NPPRIO = 3'd3;
	localparam logic [2:0] MODE_RR     = 3'd4;

	localparam logic [0:0] REG_SCHED_MODE = 1'b0;
	localparam logic [0:0] REG_TIME_SLICE = 1'b1;

	localparam logic REQ_ADMIT = 1'b0;
	localparam logic REQ_TICK  = 1'b1;

	localparam logic [7:0] SLICE_RESET = 8'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PICK,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic work_we;
		logic prio_we;
	} tbl_wr_t;

endpackage

`default_nettype wire

[rtl/tdcs_job_table.sv]
// job table memories: remaining work and priority per slot
`default_nettype none

module tdcs_job_table
	import tdcs_pkg::*;
#(
	parameter int SLOTS     = 8,
	parameter int WORK_BITS = 16,
	localparam int IW       = $clog2(SLOTS)
) (
	input  wire logic                 clk,
	input  wire tbl_wr_t              wr,
	input  wire logic [IW-1:0]        wr_addr,
	input  wire logic [WORK_BITS-1:0] wr_work,
	input  wire logic [7:0]           wr_prio,
	input  wire logic [IW-1:0]        rd_addr,
	output logic      [WORK_BITS-1:0] rd_work,
	output logic      [7:0]           rd_prio
);

	logic [WORK_BITS-1:0] work_mem [SLOTS];
	logic [7:0]           prio_mem [SLOTS];
	logic [WORK_BITS-1:0] rd_work_q;
	logic [7:0]           rd_prio_q;

	always_ff @(posedge clk) begin
		if (wr.work_we) begin
			work_mem[wr_addr] <= wr_work;
		end
		if (wr.prio_we) begin
			prio_mem[wr_addr] <= wr_prio;
		end
		rd_work_q <= work_mem[rd_addr];
		rd_prio_q <= prio_mem[rd_addr];
	end

	assign rd_work = rd_work_q;
	assign rd_prio = rd_prio_q;

endmodule

`default_nettype wire

[rtl/tick_driven_cpu_scheduler_unit.sv]
// top level of the tick driven cpu scheduler
//
// usage:
//   input beats are taken on start while busy is low. req_type selects an
//   admit (load slot with job_length and job_priority) or a tick (schedule).
//   an admit keeps busy low and gives no result; a busy slot, a slot not below
//   SLOTS or a zero length is dropped. a tick scans the job table one slot per
//   cycle through a single compare unit, then reads and decrements the picked
//   job's work. busy is high through the scan, pick and update states and
//   res_valid pulses for one cycle in the first cycle busy is low again; a new
//   tick is taken only then, set by the slot scan over the single job table read
//   port. res_valid marks a result beat; the receiver cannot stall it.
//   configuration: cfg_we with cfg_idx and cfg_wdata, which the user must give
//   only while idle; the block does not enforce it. reset clears all slots,
//   the tick counter and the running job, sets the mode to shortest remaining
//   first and the slice to 4; no clearing pass.
`default_nettype none

module tick_driven_cpu_scheduler_unit
	import tdcs_pkg::*;
#(
	parameter int SLOTS     = 8,
	parameter int WORK_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        req_type,
	input  wire logic [2:0]  slot,
	input  wire logic [15:0] job_length,
	input  wire logic [7:0]  job_priority,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_idx,
	input  wire logic [7:0]  cfg_wdata,
	output logic             res_valid,
	output logic             busy_res,
	output logic      [2:0]  run_slot,
	output logic             first_run,
	output logic             job_done,
	output logic             switched,
	output logic      [31:0] time_now
);

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int KW = (WORK_BITS > 8) ? WORK_BITS : 8;
	localparam logic [31:0] WMAX = 32'((64'd1 << WORK_BITS) - 64'd1);

	state_t state_q, state_d;

	logic [2:0]           mode_q;
	logic [7:0]           tslice_q;
	logic [SLOTS-1:0]     active_q;
	logic [SLOTS-1:0]     started_q;
	logic [IW-1:0]        run_idx_q;
	logic                 run_vld_q;
	logic [7:0]           slice_q;
	logic [31:0]          tick_q;
	logic [CW-1:0]        cnt_q;
	logic                 cmp_vld_q;
	logic [IW-1:0]        cmp_idx_q;
	logic                 best_vld_q;
	logic [IW-1:0]        best_idx_q;
	logic [KW-1:0]        best_key_q;
	logic [IW-1:0]        pick_q;
	logic                 pick_vld_q;

	logic                 res_valid_q;
	logic                 res_busy_q;
	logic [2:0]           res_slot_q;
	logic                 res_first_q;
	logic                 res_done_q;
	logic                 res_sw_q;
	logic [31:0]          res_time_q;

	logic                 accept;
	logic                 admit_ok;
	logic [IW-1:0]        slot_idx;
	logic [31:0]          len_ext;
	logic [WORK_BITS-1:0] len_sat;

	tbl_wr_t              tbl_wr;
	logic [IW-1:0]        tbl_wr_addr;
	logic [WORK_BITS-1:0] tbl_wr_work;
	logic [IW-1:0]        tbl_rd_addr;
	logic [WORK_BITS-1:0] tbl_rd_work;
	logic [7:0]           tbl_rd_prio;

	logic [IW-1:0]        rr_from;
	logic [IW:0]          rr_dist;
	logic [KW-1:0]        cmp_key;
	logic                 cmp_take;

	logic                 held;
	logic                 rr_hold;
	logic [7:0]           slice_base;
	logic [IW-1:0]        pick_d;
	logic                 pick_vld_d;
	logic [7:0]           slice_d;

	logic [WORK_BITS-1:0] work_new;
	logic                 done_new;
	logic                 first_new;
	logic                 sw_new;

	assign accept   = start && (state_q == ST_IDLE);
	assign slot_idx = IW'(slot);
	assign len_ext  = 32'(job_length);
	assign len_sat  = (len_ext > WMAX) ? WORK_BITS'(WMAX) : WORK_BITS'(len_ext);
	assign admit_ok = (32'(slot) < SLOTS) && !active_q[slot_idx] && (job_length != 16'd0);

	tdcs_job_table #(
		.SLOTS     (SLOTS),
		.WORK_BITS (WORK_BITS)
	) u_table (
		.clk     (clk),
		.wr      (tbl_wr),
		.wr_addr (tbl_wr_addr),
		.wr_work (tbl_wr_work),
		.wr_prio (job_priority),
		.rd_addr (tbl_rd_addr),
		.rd_work (tbl_rd_work),
		.rd_prio (tbl_rd_prio)
	);

	// round robin distance from the slot after the last one run
	always_comb begin
		rr_from = '0;
		if (run_vld_q) begin
			rr_from = (run_idx_q == IW'(SLOTS - 1)) ? '0 : run_idx_q + 1'b1;
		end
		rr_dist = {1'b0, cmp_idx_q} - {1'b0, rr_from};
		if (cmp_idx_q < rr_from) begin
			rr_dist = {1'b0, cmp_idx_q} + (IW + 1)'(SLOTS) - {1'b0, rr_from};
		end
	end

	// shared compare unit
	always_comb begin
		case (mode_q)
			MODE_PPRIO, MODE_NPPRIO: cmp_key = KW'(tbl_rd_prio);
			MODE_RR:                 cmp_key = KW'(rr_dist);
			default:                 cmp_key = KW'(tbl_rd_work);
		endcase
		cmp_take = cmp_vld_q && active_q[cmp_idx_q] && (!best_vld_q || (cmp_key < best_key_q));
	end

	// pick from scan result and hold rules
	always_comb begin
		held       = run_vld_q && active_q[run_idx_q] && started_q[run_idx_q];
		rr_hold    = held && (slice_q != 8'd0);
		slice_base = 8'd0;
		pick_d     = best_idx_q;
		pick_vld_d = best_vld_q;
		slice_d    = 8'd0;
		case (mode_q)
			MODE_SJF, MODE_NPPRIO: begin
				if (held) begin
					pick_d     = run_idx_q;
					pick_vld_d = 1'b1;
				end
			end
			MODE_RR: begin
				if (rr_hold) begin
					pick_d     = run_idx_q;
					pick_vld_d = 1'b1;
					slice_base = slice_q;
				end else begin
					slice_base = (tslice_q == 8'd0) ? 8'd1 : tslice_q;
				end
				slice_d = (pick_vld_d && (slice_base != 8'd0)) ? slice_base - 8'd1 : slice_base;
			end
			default: begin
				pick_d     = best_idx_q;
				pick_vld_d = best_vld_q;
			end
		endcase
	end

	always_comb begin
		work_new  = tbl_rd_work - 1'b1;
		done_new  = (work_new == '0);
		first_new = !started_q[pick_q];
		sw_new    = !(run_vld_q && (run_idx_q == pick_q) && !first_new);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (req_type == REQ_TICK)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cnt_q == CW'(SLOTS)) begin
					state_d = ST_PICK;
				end
			end
			ST_PICK:   state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		busy        = 1'b1;
		tbl_wr      = '0;
		tbl_wr_addr = slot_idx;
		tbl_wr_work = len_sat;
		tbl_rd_addr = cnt_q[IW-1:0];
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (accept && (req_type == REQ_ADMIT) && admit_ok) begin
					tbl_wr.work_we = 1'b1;
					tbl_wr.prio_we = 1'b1;
				end
			end
			ST_SCAN: tbl_rd_addr = cnt_q[IW-1:0];
			ST_PICK: tbl_rd_addr = pick_d;
			ST_UPDATE: begin
				tbl_wr.work_we = pick_vld_q;
				tbl_wr_addr    = pick_q;
				tbl_wr_work    = work_new;
			end
			default: busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_SRTF;
			tslice_q <= SLICE_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SCHED_MODE: mode_q   <= cfg_wdata[2:0];
				REG_TIME_SLICE: tslice_q <= cfg_wdata;
				default:        mode_q   <= mode_q;
			endcase
		end
	end

	// scan counter and compare pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			cmp_vld_q  <= 1'b0;
			cmp_idx_q  <= '0;
			best_vld_q <= 1'b0;
			best_idx_q <= '0;
			best_key_q <= '0;
		end else begin
			cmp_vld_q <= (state_q == ST_SCAN) && (cnt_q != CW'(SLOTS));
			cmp_idx_q <= cnt_q[IW-1:0];
			if (state_q == ST_SCAN) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (state_q == ST_IDLE) begin
				best_vld_q <= 1'b0;
			end else if (cmp_take) begin
				best_vld_q <= 1'b1;
				best_idx_q <= cmp_idx_q;
				best_key_q <= cmp_key;
			end
		end
	end

	// job state and result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= '0;
			started_q   <= '0;
			run_idx_q   <= '0;
			run_vld_q   <= 1'b0;
			slice_q     <= '0;
			tick_q      <= '0;
			pick_q      <= '0;
			pick_vld_q  <= 1'b0;
			res_valid_q <= 1'b0;
			res_busy_q  <= 1'b0;
			res_slot_q  <= '0;
			res_first_q <= 1'b0;
			res_done_q  <= 1'b0;
			res_sw_q    <= 1'b0;
			res_time_q  <= '0;
		end else begin
			res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && (req_type == REQ_ADMIT) && admit_ok) begin
						active_q[slot_idx]  <= 1'b1;
						started_q[slot_idx] <= 1'b0;
					end
				end
				ST_PICK: begin
					pick_q     <= pick_d;
					pick_vld_q <= pick_vld_d;
					slice_q    <= slice_d;
				end
				ST_UPDATE: begin
					res_valid_q <= 1'b1;
					res_time_q  <= tick_q;
					tick_q      <= tick_q + 32'd1;
					res_busy_q  <= pick_vld_q;
					res_slot_q  <= pick_vld_q ? 3'(pick_q) : 3'd0;
					res_first_q <= pick_vld_q && first_new;
					res_done_q  <= pick_vld_q && done_new;
					res_sw_q    <= pick_vld_q && sw_new;
					if (pick_vld_q) begin
						started_q[pick_q] <= 1'b1;
						if (done_new) begin
							active_q[pick_q] <= 1'b0;
						end
						run_idx_q <= pick_q;
						run_vld_q <= 1'b1;
					end
				end
				default: begin
					res_valid_q <= 1'b0;
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign busy_res  = res_busy_q;
	assign run_slot  = res_slot_q;
	assign first_run = res_first_q;
	assign job_done  = res_done_q;
	assign switched  = res_sw_q;
	assign time_now  = res_time_q;

endmodule

`default_nettype wire

[rtl/tdcs_checker.sv]
// port-level checks for the tick driven cpu scheduler, bound to the top level
`default_nettype none
`include "tick_driven_cpu_scheduler_unit_macros.svh"

module tdcs_checker
	import tdcs_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        req_type,
	input wire logic [2:0]  slot,
	input wire logic [15:0] job_length,
	input wire logic [7:0]  job_priority,
	input wire logic        cfg_we,
	input wire logic [0:0]  cfg_idx,
	input wire logic [7:0]  cfg_wdata,
	input wire logic        res_valid,
	input wire logic        busy_res,
	input wire logic [2:0]  run_slot,
	input wire logic        first_run,
	input wire logic        job_done,
	input wire logic        switched,
	input wire logic [31:0] time_now
);

	// a result beat comes only once the sequencer is back to idle
	`TDCS_ASSERT_IMP(a_res_idle, clk, arst_n, res_valid, !busy)
	// a tick beat starts the slot scan
	`TDCS_ASSERT_NXT(a_tick_busy, clk, arst_n, start && !busy && (req_type == REQ_TICK), busy)
	// an admit beat finishes at once and gives no result
	`TDCS_ASSERT_NXT(a_admit_quiet, clk, arst_n, start && !busy && (req_type == REQ_ADMIT),
		!busy && !res_valid)
	// idle tick reports nothing but the time
	`TDCS_ASSERT_IMP(a_idle_tick, clk, arst_n, res_valid && !busy_res,
		(run_slot == 3'd0) && !first_run && !job_done && !switched)

endmodule

bind tick_driven_cpu_scheduler_unit tdcs_checker u_tdcs_checker (.*);

`default_nettype wire

[tb/tb_tick_driven_cpu_scheduler_unit.sv]
// self-checking testbench for the tick driven cpu scheduler unit
`timescale 1ns / 1ps

module tb_tick_driven_cpu_scheduler_unit;
	import tdcs_pkg::*;

	localparam int SLOTS = 8;
	localparam int IDLE_LIMIT = 2000;
	localparam logic [2:0] MODE_SPARE_LO = 3'd5;
	localparam logic [2:0] MODE_SPARE_HI = 3'd7;

	typedef struct packed {
		logic        busy_res;
		logic [2:0]  run_slot;
		logic        first_run;
		logic        job_done;
		logic        switched;
		logic [31:0] time_now;
	} tick_report_t;

	class sched_scoreboard;
		logic [15:0]      work_left [SLOTS];
		logic [7:0]       prio_of [SLOTS];
		logic [SLOTS-1:0] active;
		logic [SLOTS-1:0] started;
		logic [2:0]       last_slot;
		logic             last_valid;
		logic [7:0]       slice_left;
		logic [31:0]      tick_count;
		logic [2:0]       mode;
		logic [7:0]       quantum;
		tick_report_t     pending_reports [$];
		int               failures;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				work_left[i] = '0;
				prio_of[i] = '0;
			end
			active = '0;
			started = '0;
			last_slot = '0;
			last_valid = 1'b0;
			slice_left = '0;
			tick_count = '0;
			mode = MODE_SRTF;
			quantum = SLICE_RESET;
			failures = 0;
		endfunction

		function void set_reg(logic [0:0] idx, logic [7:0] val);
			if (idx == REG_SCHED_MODE)
				mode = val[2:0];
			else
				quantum = val;
		endfunction

		function int lowest_key_slot(bit by_prio);
			int best;
			int best_key;
			int key;
			best = -1;
			best_key = 0;
			for (int i = 0; i < SLOTS; i++) begin
				key = by_prio ? int'(prio_of[i]) : int'(work_left[i]);
				if (active[i] && (best < 0 || key < best_key)) begin
					best = i;
					best_key = key;
				end
			end
			return best;
		endfunction

		// returns 1 when the beat changes the job table or schedules a tick
		function bit note_input(logic req, logic [2:0] s, logic [15:0] len, logic [7:0] pr);
			tick_report_t r;
			int pick;
			int k;
			bit held;
			logic [2:0] from;
			if (req == REQ_ADMIT) begin
				if (active[s] || len == 16'd0)
					return 1'b0;
				work_left[s] = len;
				prio_of[s] = pr;
				active[s] = 1'b1;
				started[s] = 1'b0;
				return 1'b1;
			end
			held = last_valid && active[last_slot] && started[last_slot];
			case (mode)
				MODE_SJF: begin
					pick = held ? int'(last_slot) : lowest_key_slot(1'b0);
					slice_left = '0;
				end
				MODE_PPRIO: begin
					pick = lowest_key_slot(1'b1);
					slice_left = '0;
				end
				MODE_NPPRIO: begin
					pick = held ? int'(last_slot) : lowest_key_slot(1'b1);
					slice_left = '0;
				end
				MODE_RR: begin
					if (held && slice_left != 0) begin
						pick = int'(last_slot);
					end else begin
						from = last_valid ? last_slot + 3'd1 : 3'd0;
						pick = -1;
						for (k = 0; k < SLOTS; k++)
							if (pick < 0 && active[3'(from + k)])
								pick = int'(3'(from + k));
						slice_left = (quantum == 0) ? 8'd1 : quantum;
					end
					if (pick >= 0 && slice_left != 0)
						slice_left = slice_left - 8'd1;
				end
				default: begin
					pick = lowest_key_slot(1'b0);
					slice_left = '0;
				end
			endcase
			r = '0;
			r.time_now = tick_count;
			tick_count = tick_count + 32'd1;
			if (pick >= 0) begin
				r.busy_res = 1'b1;
				r.run_slot = 3'(pick);
				r.first_run = !started[pick];
				r.switched = !(last_valid && last_slot == 3'(pick) && !r.first_run);
				started[pick] = 1'b1;
				work_left[pick] = work_left[pick] - 16'd1;
				r.job_done = work_left[pick] == 16'd0;
				if (r.job_done)
					active[pick] = 1'b0;
				last_slot = 3'(pick);
				last_valid = 1'b1;
			end
			pending_reports.push_back(r);
			return 1'b1;
		endfunction

		function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				failures++;
			end
		endfunction

		function void check_result(tick_report_t got);
			tick_report_t want;
			if (pending_reports.size() == 0) begin
				$error("result beat with nothing expected");
				failures++;
				return;
			end
			want = pending_reports.pop_front();
			cmp_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
			cmp_field("run_slot", 32'(want.run_slot), 32'(got.run_slot));
			cmp_field("first_run", 32'(want.first_run), 32'(got.first_run));
			cmp_field("job_done", 32'(want.job_done), 32'(got.job_done));
			cmp_field("switched", 32'(want.switched), 32'(got.switched));
			cmp_field("time_now", want.time_now, got.time_now);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        req_type = REQ_TICK;
	logic [2:0]  slot = '0;
	logic [15:0] job_length = '0;
	logic [7:0]  job_priority = '0;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_idx = REG_SCHED_MODE;
	logic [7:0]  cfg_wdata = '0;
	logic        busy;
	logic        res_valid;
	logic        busy_res;
	logic [2:0]  run_slot;
	logic        first_run;
	logic        job_done;
	logic        switched;
	logic [31:0] time_now;

	sched_scoreboard sb = new();
	int applied = 0;
	bit gaps_on = 1'b1;
	int idle_cycles = 0;

	tick_driven_cpu_scheduler_unit #(
		.SLOTS(SLOTS),
		.WORK_BITS(16)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.slot(slot),
		.job_length(job_length),
		.job_priority(job_priority),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.res_valid(res_valid),
		.busy_res(busy_res),
		.run_slot(run_slot),
		.first_run(first_run),
		.job_done(job_done),
		.switched(switched),
		.time_now(time_now)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && res_valid)
			sb.check_result({busy_res, run_slot, first_run, job_done, switched, time_now});
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || res_valid || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("tick_driven_cpu_scheduler_unit regression: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_beat(logic req, logic [2:0] s, logic [15:0] len, logic [7:0] pr);
		if (gaps_on && $urandom_range(99) < 16) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= req;
		slot <= s;
		job_length <= len;
		job_priority <= pr;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (sb.note_input(req, s, len, pr))
			applied++;
	endtask

	task automatic admit(logic [2:0] s, logic [15:0] len, logic [7:0] pr);
		send_beat(REQ_ADMIT, s, len, pr);
	endtask

	task automatic tick();
		send_beat(REQ_TICK, 3'($urandom_range(7)), 16'($urandom_range(16'hFFFF)),
			8'($urandom_range(255)));
	endtask

	// hold off until every tick beat has reported, then let the block settle
	task automatic settle();
		start <= 1'b0;
		while (sb.pending_reports.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic configure(logic [7:0] mode_val, logic [7:0] slice_val);
		cfg_we <= 1'b1;
		cfg_idx <= REG_SCHED_MODE;
		cfg_wdata <= mode_val;
		@(posedge clk);
		sb.set_reg(REG_SCHED_MODE, mode_val);
		cfg_idx <= REG_TIME_SLICE;
		cfg_wdata <= slice_val;
		@(posedge clk);
		sb.set_reg(REG_TIME_SLICE, slice_val);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int phase;
		int target;
		int r;
		int lr;
		logic [2:0] s;
		logic [7:0] mode_val;
		logic [7:0] slice_val;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle tick, ignored admits, ties, every mode, spare mode, zero slice
		configure(8'(MODE_SRTF), SLICE_RESET);
		tick();
		admit(3'd0, 16'd3, 8'd5);
		admit(3'd7, 16'd1, 8'd0);
		admit(3'd0, 16'hFFFF, 8'hFF);
		admit(3'd3, 16'd0, 8'd0);
		admit(3'd4, 16'd3, 8'd0);
		repeat (3) tick();
		settle();
		configure(8'(MODE_PPRIO), SLICE_RESET);
		admit(3'd1, 16'd2, 8'd0);
		repeat (2) tick();
		settle();
		configure(8'(MODE_NPPRIO), SLICE_RESET);
		repeat (2) tick();
		settle();
		configure(8'(MODE_SJF), SLICE_RESET);
		admit(3'd2, 16'd2, 8'd9);
		repeat (2) tick();
		settle();
		configure(8'(MODE_RR), 8'd1);
		admit(3'd6, 16'd4, 8'd1);
		repeat (3) tick();
		settle();
		configure(8'(MODE_SPARE_LO), 8'd0);
		repeat (2) tick();
		settle();
		configure(8'(MODE_RR), 8'd0);
		repeat (3) tick();

		phase = 0;
		while (applied < 560) begin
			settle();
			r = $urandom_range(99);
			if (r < 90)
				mode_val = 8'($urandom_range(MODE_SRTF, MODE_RR));
			else
				mode_val = 8'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
			r = $urandom_range(5);
			case (r)
				0: slice_val = 8'd1;
				1: slice_val = 8'd255;
				2: slice_val = 8'd2;
				3: slice_val = 8'd3;
				default: slice_val = 8'($urandom_range(255));
			endcase
			configure(mode_val, slice_val);
			gaps_on = (phase != 2);
			target = applied + 50;
			while (applied < target) begin
				r = $urandom_range(99);
				if (r < 20 && sb.active != '1) begin
					do s = 3'($urandom_range(7)); while (sb.active[s]);
					lr = $urandom_range(99);
					admit(s,
						16'(lr < 80 ? $urandom_range(1, 3) :
						lr < 97 ? $urandom_range(4, 12) : $urandom_range(13, 48)),
						8'($urandom_range(1) ? $urandom_range(3) : $urandom_range(255)));
				end else if (r < 24) begin
					if ($urandom_range(1) && sb.active != '0) begin
						do s = 3'($urandom_range(7)); while (!sb.active[s]);
						admit(s, 16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)));
					end else begin
						admit(3'($urandom_range(7)), 16'd0, 8'($urandom_range(255)));
					end
				end else begin
					tick();
				end
			end
			phase++;
		end

		// longest job, admitted last so it cannot hog the table
		settle();
		configure(8'(MODE_SRTF), SLICE_RESET);
		gaps_on = 1'b1;
		while (sb.active == '1) tick();
		do s = 3'($urandom_range(7)); while (sb.active[s]);
		admit(s, 16'hFFFF, 8'hFF);
		repeat (4) tick();

		start <= 1'b0;
		while (sb.pending_reports.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.failures == 0 && sb.pending_reports.size() == 0)
			$display("tick_driven_cpu_scheduler_unit regression: pass");
		else
			$display("tick_driven_cpu_scheduler_unit regression: fail");
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl
rtl/tdcs_pkg.sv
rtl/tdcs_job_table.sv
rtl/tick_driven_cpu_scheduler_unit.sv
rtl/tdcs_checker.sv
tb/tb_tick_driven_cpu_scheduler_unit.sv
